// File: rtl/cig_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cig_pkg: shared types and constants for the CIGAR text geometry block
// Field widths, op letter codes, the decoded character token that travels
// from the front end to the back end, and the classifier function.
// ----------------------------------------------------------------------------
package cig_pkg;

    // Width of one decimal run length and of the span sums
    localparam int RUN_LEN_BITS = 28;
    localparam int SPAN_BITS    = 32;

    // Product width of run*10 + digit
    localparam int PROD_W = RUN_LEN_BITS + 4;
    // Width of span sum plus run length, one carry bit on top
    localparam int SUM_W  = (SPAN_BITS > RUN_LEN_BITS ? SPAN_BITS : RUN_LEN_BITS) + 1;
    // Width used for the final coordinates, at least 33 bits
    localparam int WIDE_W = (SPAN_BITS > 32 ? SPAN_BITS : 32) + 1;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_X  = 8'h58;

    // One classified character
    typedef struct packed {
        logic        is_digit;
        logic [3:0]  digit;
        logic        known;     // one of the op letters
        logic        cons_q;    // adds to query span (H included)
        logic        cons_r;    // adds to reference span
        logic        is_clip;   // S or H
        logic        last;
        logic [30:0] ref_start;
        logic        minus;
    } t_tok;

    // Op letter decode: {known, cons_q, cons_r, is_clip}
    typedef struct packed {
        logic known;
        logic cons_q;
        logic cons_r;
        logic is_clip;
    } t_op_class;

    function automatic t_op_class op_class(input logic [7:0] c);
        t_op_class k;
        k = '0;
        unique case (c) inside
            CH_M, CH_EQ, CH_X: k = '{known: 1'b1, cons_q: 1'b1, cons_r: 1'b1, is_clip: 1'b0};
            CH_I:              k = '{known: 1'b1, cons_q: 1'b1, cons_r: 1'b0, is_clip: 1'b0};
            CH_D, CH_N:        k = '{known: 1'b1, cons_q: 1'b0, cons_r: 1'b1, is_clip: 1'b0};
            CH_S, CH_H:        k = '{known: 1'b1, cons_q: 1'b1, cons_r: 1'b0, is_clip: 1'b1};
            CH_P:              k = '{known: 1'b1, cons_q: 1'b0, cons_r: 1'b0, is_clip: 1'b0};
            default:           k = '0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: rtl/cig_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cig_if: valid/ready channels of the CIGAR text geometry block
// Input channel carries one text character per beat, output channel one
// geometry result per beat.
// ----------------------------------------------------------------------------
interface cig_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_char;
    logic        last_char;
    logic [30:0] ref_start;
    logic        minus_strand;

    modport source (output valid, text_char, last_char, ref_start, minus_strand,
                    input ready);
    modport sink   (input valid, text_char, last_char, ref_start, minus_strand,
                    output ready);
endinterface

interface cig_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] query_begin;
    logic [31:0] query_finish;
    logic [30:0] ref_begin;
    logic [31:0] ref_finish;

    modport source (output valid, valid_res, query_begin, query_finish, ref_begin,
                    ref_finish, input ready);
    modport sink   (input valid, valid_res, query_begin, query_finish, ref_begin,
                    ref_finish, output ready);
endinterface
`default_nettype wire

// File: rtl/cigar_text_alignment_geometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_text_alignment_geometry: CIGAR text parser with alignment geometry
// Top level: classifier front end, token queue, accumulator back end.
// ----------------------------------------------------------------------------
// Feed a CIGAR text one character per beat, marking its final character with
// last_char; ref_start and minus_strand are taken from that final beat. One
// character is taken every cycle while the four-entry token queue has room;
// the accumulator retires one character a cycle, except that a final character
// waits while the finish stage is full, so the sustained rate is one character
// per cycle while the result side keeps up. The final character is written
// into a queue entry; its result then passes the finish stage and the output
// register, and is later by the queue occupancy. The output register and
// the finish stage let a new text stream in while a result waits to be taken.
// A malformed text or an overflow gives valid_res = 0 with all coordinates 0.
// ----------------------------------------------------------------------------
module cigar_text_alignment_geometry
    import cig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cig_in_if.sink    i_in,
    cig_out_if.source o_out
);

    logic w_push, w_full, w_qvalid, w_pop;
    t_tok w_tok_in, w_tok_out;

    cig_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_tok   (w_tok_in)
    );

    cig_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_tok_in),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_tok   (w_tok_out),
        .i_pop   (w_pop)
    );

    cig_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_qvalid),
        .i_tok       (w_tok_out),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/cig_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cig_front: character classifier
// Accepts input beats while the token queue has room and decodes each
// character into a digit or an op class token.
// ----------------------------------------------------------------------------
module cig_front
    import cig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cig_in_if.sink    i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_tok      o_tok
);

    t_op_class w_cls;

    // Accept whenever the queue can take the token
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Decode the character
    always_comb begin
        w_cls           = op_class(i_in.text_char);
        o_tok           = '0;
        o_tok.is_digit  = (i_in.text_char >= CH_0) && (i_in.text_char <= CH_9);
        o_tok.digit     = 4'(i_in.text_char - CH_0);
        o_tok.known     = w_cls.known;
        o_tok.cons_q    = w_cls.cons_q;
        o_tok.cons_r    = w_cls.cons_r;
        o_tok.is_clip   = w_cls.is_clip;
        o_tok.last      = i_in.last_char;
        o_tok.ref_start = i_in.ref_start;
        o_tok.minus     = i_in.minus_strand;
    end

    // A stalled beat never reaches the queue
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push) else $error("push into full queue");
    a_push_is_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push == (i_in.valid && i_in.ready)) else $error("push without beat");
    a_digit_not_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_tok.is_digit |-> !o_tok.known) else $error("digit classed as op");

endmodule
`default_nettype wire

// File: rtl/cig_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cig_queue: token queue between front and back
// Small circular queue of classified characters; push and pop may happen in
// the same cycle.
// ----------------------------------------------------------------------------
module cig_queue
    import cig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_tok      i_tok,
    output logic      o_full,
    output logic      o_valid,
    output t_tok      o_tok,
    input  wire logic i_pop
);

    t_tok              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overrun");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_cnt == QCNT_W'(QUEUE_DEPTH)) |-> r_wr == r_rd)
        else $error("queue pointers out of step");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("lost push");

endmodule
`default_nettype wire

// File: rtl/cig_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cig_back: run accumulator and geometry output
// Consumes one token a cycle, a last one only once the finish stage is free:
// digits build the run, ops add to spans and record clips. The last token
// snapshots the sums there to form the strand adjusted output coordinates.
// ----------------------------------------------------------------------------
module cig_back
    import cig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_tok_valid,
    input  t_tok      i_tok,
    output logic      o_pop,
    cig_out_if.source o_out
);

    // Parse state
    logic [RUN_LEN_BITS-1:0] r_run, n_run;
    logic                    r_digits, n_digits;
    logic                    r_any, n_any;
    logic [RUN_LEN_BITS-1:0] r_left, n_left;
    logic [RUN_LEN_BITS-1:0] r_right, n_right;
    logic [SPAN_BITS-1:0]    r_qsum, n_qsum;
    logic [SPAN_BITS-1:0]    r_rsum, n_rsum;
    logic                    r_err, n_err;

    // Finish stage
    logic                    r_fv;
    logic                    r_f_err;
    logic [RUN_LEN_BITS-1:0] r_f_left, r_f_right;
    logic [SPAN_BITS-1:0]    r_f_qsum, r_f_rsum;
    logic [30:0]             r_f_rs;
    logic                    r_f_minus;

    // Output register
    logic                    r_ov;
    logic                    r_o_valid_res;
    logic [31:0]             r_o_qb, r_o_qf, r_o_rf;
    logic [30:0]             r_o_rb;

    logic [PROD_W-1:0]       w_prod;
    logic [SUM_W-1:0]        w_qadd, w_radd;
    logic                    w_out_free, w_fin_adv, w_fin_free, w_load_fin;
    logic [WIDE_W-1:0]       w_qb, w_qf, w_rf;
    logic                    w_f_bad;

    // Stage handshakes
    assign w_out_free = !r_ov || o_out.ready;
    assign w_fin_adv  = r_fv && w_out_free;
    assign w_fin_free = !r_fv || w_fin_adv;
    assign o_pop      = i_tok_valid && (!i_tok.last || w_fin_free);
    assign w_load_fin = o_pop && i_tok.last;

    // Run and span arithmetic
    assign w_prod = (PROD_W'(r_run) << 3) + (PROD_W'(r_run) << 1) + PROD_W'(i_tok.digit);
    assign w_qadd = SUM_W'(r_qsum) + SUM_W'(r_run);
    assign w_radd = SUM_W'(r_rsum) + SUM_W'(r_run);

    // Next parse state for the popped token
    always_comb begin
        n_run    = r_run;
        n_digits = r_digits;
        n_any    = r_any;
        n_left   = r_left;
        n_right  = r_right;
        n_qsum   = r_qsum;
        n_rsum   = r_rsum;
        n_err    = r_err;
        if (o_pop && !r_err) begin
            if (i_tok.is_digit) begin
                if (w_prod[PROD_W-1:RUN_LEN_BITS] != '0) begin
                    n_err = 1'b1;
                end else begin
                    n_run    = w_prod[RUN_LEN_BITS-1:0];
                    n_digits = 1'b1;
                end
            end else if (!i_tok.known || !r_digits) begin
                n_err = 1'b1;
            end else begin
                // after an error the sums are dead, so both checks run freely
                if (i_tok.cons_q) begin
                    if (w_qadd[SUM_W-1:SPAN_BITS] != '0) begin
                        n_err = 1'b1;
                    end
                    n_qsum = w_qadd[SPAN_BITS-1:0];
                end
                if (i_tok.cons_r) begin
                    if (w_radd[SUM_W-1:SPAN_BITS] != '0) begin
                        n_err = 1'b1;
                    end
                    n_rsum = w_radd[SPAN_BITS-1:0];
                end
                if (!r_any && i_tok.is_clip) begin
                    n_left = r_run;
                end
                n_right  = i_tok.is_clip ? r_run : '0;
                n_any    = 1'b1;
                n_run    = '0;
                n_digits = 1'b0;
            end
        end
    end

    // Parse state register; cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load_fin) begin
            r_run    <= '0;
            r_digits <= 1'b0;
            r_any    <= 1'b0;
            r_left   <= '0;
            r_right  <= '0;
            r_qsum   <= '0;
            r_rsum   <= '0;
            r_err    <= 1'b0;
        end else begin
            r_run    <= n_run;
            r_digits <= n_digits;
            r_any    <= n_any;
            r_left   <= n_left;
            r_right  <= n_right;
            r_qsum   <= n_qsum;
            r_rsum   <= n_rsum;
            r_err    <= n_err;
        end
    end

    // Finish stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_load_fin) begin
            r_fv <= 1'b1;
        end else if (w_fin_adv) begin
            r_fv <= 1'b0;
        end
    end

    // Finish stage payload: snapshot of the closing state
    always_ff @(posedge i_clk) begin
        if (w_load_fin) begin
            r_f_err   <= n_err || n_digits || !n_any;
            r_f_left  <= n_left;
            r_f_right <= n_right;
            r_f_qsum  <= n_qsum;
            r_f_rsum  <= n_rsum;
            r_f_rs    <= i_tok.ref_start;
            r_f_minus <= i_tok.minus;
        end
    end

    // Strand adjusted coordinates and 32 bit range check
    always_comb begin
        if (r_f_minus) begin
            w_qb = WIDE_W'(r_f_right);
            w_qf = WIDE_W'(r_f_qsum) - WIDE_W'(r_f_left);
        end else begin
            w_qb = WIDE_W'(r_f_left);
            w_qf = WIDE_W'(r_f_qsum) - WIDE_W'(r_f_right);
        end
        w_rf    = WIDE_W'(r_f_rs) + WIDE_W'(r_f_rsum);
        w_f_bad = r_f_err || (w_rf[WIDE_W-1:32] != '0) || (w_qb[WIDE_W-1:32] != '0)
                  || (w_qf[WIDE_W-1:32] != '0);
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_free) begin
            r_ov <= r_fv;
        end
    end

    // Output register payload; invalid results read as zeros
    always_ff @(posedge i_clk) begin
        if (w_fin_adv) begin
            r_o_valid_res <= !w_f_bad;
            r_o_qb        <= w_f_bad ? '0 : w_qb[31:0];
            r_o_qf        <= w_f_bad ? '0 : w_qf[31:0];
            r_o_rb        <= w_f_bad ? '0 : r_f_rs;
            r_o_rf        <= w_f_bad ? '0 : w_rf[31:0];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.valid_res    = r_o_valid_res;
    assign o_out.query_begin  = r_o_qb;
    assign o_out.query_finish = r_o_qf;
    assign o_out.ref_begin    = r_o_rb;
    assign o_out.ref_finish   = r_o_rf;

    a_state_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_fin |=> r_run == '0 && !r_digits && !r_any && !r_err)
        else $error("parse state not cleared after last character");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv && !w_fin_adv |=> r_fv && $stable(r_f_qsum) && $stable(r_f_rs))
        else $error("finish stage overwritten while stalled");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_o_valid_res |-> r_o_qb == '0 && r_o_qf == '0 && r_o_rb == '0
        && r_o_rf == '0) else $error("invalid result carries coordinates");
    a_ref_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_valid_res |-> r_o_rf >= {1'b0, r_o_rb})
        else $error("reference end before start");

endmodule
`default_nettype wire

// File: verif/cigar_text_alignment_geometry_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_text_alignment_geometry_tb: self-checking bench for the CIGAR parser
// CIGAR texts are streamed one character per beat. A scoreboard class tracks
// run lengths, spans and clips for each accepted character. It predicts the
// geometry of each text and compares every result beat field by field. A
// directed set covers clips, every op, malformed text and overflow limits.
// Random well-formed texts follow, with broken texts and noise mixed in, and
// both channels stall at random.
// ----------------------------------------------------------------------------
module cigar_text_alignment_geometry_tb;
    import cig_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] RUN_LIMIT    = 64'd1 << RUN_LEN_BITS;
    localparam logic [63:0] SPAN_LIMIT   = 64'd1 << SPAN_BITS;
    localparam logic [63:0] COORD_MAX    = 64'hFFFF_FFFF;
    localparam int unsigned RUN_MAX      = (1 << RUN_LEN_BITS) - 1;
    localparam logic [30:0] REF_MAX      = 31'h7FFF_FFFF;
    localparam int          STALL_PCT    = 12;
    localparam int          QUIET_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 20;

    // One geometry result as seen on the output channel
    typedef struct packed {
        logic        valid_res;
        logic [31:0] query_begin;
        logic [31:0] query_finish;
        logic [30:0] ref_begin;
        logic [31:0] ref_finish;
    } t_geometry;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parse state of the current text and holds the
    // geometry expected for each text that has ended
    // ------------------------------------------------------------------------
    class cigar_geometry_checker;
        logic [63:0] run_len;
        logic [63:0] lead_clip;
        logic [63:0] tail_clip;
        logic [63:0] qry_span;
        logic [63:0] ref_span;
        bit          digits_seen;
        bit          op_seen;
        bit          parse_err;
        t_geometry   pending_geometry[$];
        int unsigned mismatch_count;

        function new();
            run_len        = '0;
            lead_clip      = '0;
            tail_clip      = '0;
            qry_span       = '0;
            ref_span       = '0;
            digits_seen    = 1'b0;
            op_seen        = 1'b0;
            parse_err      = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return pending_geometry.size();
        endfunction

        // Accepted input beat: advance the parse, and on the last character
        // queue the expected geometry and clear for the next text
        function void take_char(logic [7:0] c, logic last, logic [30:0] rs, logic minus);
            logic [63:0] n;
            logic [63:0] q;
            logic [63:0] r;
            logic [63:0] qb;
            logic [63:0] qf;
            logic [63:0] rf;
            bit          known;
            bit          adds_q;
            bit          adds_r;
            bit          clip;
            bit          err;
            t_geometry   g;

            // once a text has failed its remaining characters are ignored
            if (!parse_err) begin
                if (c >= CH_0 && c <= CH_9) begin
                    n = run_len * 10 + (c - CH_0);
                    if (n >= RUN_LIMIT) begin
                        parse_err = 1'b1;
                    end else begin
                        run_len     = n;
                        digits_seen = 1'b1;
                    end
                end else begin
                    known  = 1'b1;
                    adds_q = 1'b0;
                    adds_r = 1'b0;
                    clip   = 1'b0;
                    case (c) inside
                        CH_M, CH_EQ, CH_X: begin
                            adds_q = 1'b1;
                            adds_r = 1'b1;
                        end
                        CH_I:       adds_q = 1'b1;
                        CH_D, CH_N: adds_r = 1'b1;
                        CH_S, CH_H: begin
                            adds_q = 1'b1;
                            clip   = 1'b1;
                        end
                        CH_P:       known = 1'b1;
                        default:    known = 1'b0;
                    endcase
                    q = qry_span + (adds_q ? run_len : 64'd0);
                    r = ref_span + (adds_r ? run_len : 64'd0);
                    if (!known || !digits_seen || q >= SPAN_LIMIT || r >= SPAN_LIMIT) begin
                        parse_err = 1'b1;
                    end else begin
                        qry_span = q;
                        ref_span = r;
                        if (!op_seen && clip)
                            lead_clip = run_len;
                        tail_clip   = clip ? run_len : 64'd0;
                        op_seen     = 1'b1;
                        run_len     = '0;
                        digits_seen = 1'b0;
                    end
                end
            end

            if (last) begin
                err = parse_err || digits_seen || !op_seen;
                g   = '0;
                if (!err) begin
                    qb = minus ? tail_clip : lead_clip;
                    qf = qry_span - (minus ? lead_clip : tail_clip);
                    rf = {33'd0, rs} + ref_span;
                    if (rf > COORD_MAX || qb > COORD_MAX || qf > COORD_MAX)
                        err = 1'b1;
                    if (!err) begin
                        g.valid_res    = 1'b1;
                        g.query_begin  = qb[31:0];
                        g.query_finish = qf[31:0];
                        g.ref_begin    = rs;
                        g.ref_finish   = rf[31:0];
                    end
                end
                pending_geometry.insert(pending_geometry.size(), g);
                run_len     = '0;
                lead_clip   = '0;
                tail_clip   = '0;
                qry_span    = '0;
                ref_span    = '0;
                digits_seen = 1'b0;
                op_seen     = 1'b0;
                parse_err   = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatch_count++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
        endtask

        // Accepted result beat: compare with the oldest expected geometry
        task check_geometry(t_geometry got);
            t_geometry want;
            if (pending_geometry.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected, valid_res=%0b",
                                          got.valid_res));
                return;
            end
            want = pending_geometry.pop_front();
            compare_field("valid_res", {31'd0, got.valid_res}, {31'd0, want.valid_res});
            compare_field("query_begin", got.query_begin, want.query_begin);
            compare_field("query_finish", got.query_finish, want.query_finish);
            compare_field("ref_begin", {1'b0, got.ref_begin}, {1'b0, want.ref_begin});
            compare_field("ref_finish", got.ref_finish, want.ref_finish);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;                 // no stalls on either side while set
    logic [7:0] text_buf[$];      // characters of the text being sent

    cigar_geometry_checker checker_h = new();

    cig_in_if  chan_in ();
    cig_out_if chan_out ();

    cigar_text_alignment_geometry i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chan_in.sink),
        .o_out   (chan_out.source)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        chan_out.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Beat monitors and watchdog
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (chan_in.valid && chan_in.ready)
                checker_h.take_char(chan_in.text_char, chan_in.last_char,
                                    chan_in.ref_start, chan_in.minus_strand);
            if (chan_out.valid && chan_out.ready)
                checker_h.check_geometry('{chan_out.valid_res, chan_out.query_begin,
                                           chan_out.query_finish, chan_out.ref_begin,
                                           chan_out.ref_finish});
            if ((chan_in.valid && chan_in.ready) || (chan_out.valid && chan_out.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no beat for %0d cycles", $realtime, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [7:0] op_letter(int unsigned idx);
        case (idx)
            0:       return CH_M;
            1:       return CH_I;
            2:       return CH_D;
            3:       return CH_N;
            4:       return CH_S;
            5:       return CH_H;
            6:       return CH_P;
            7:       return CH_EQ;
            default: return CH_X;
        endcase
    endfunction

    // Mostly short runs, now and then one anywhere up to the run length limit
    function automatic int unsigned rand_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 20);
        if (pick < 95)
            return $urandom_range(0, 9999);
        return $urandom_range(0, RUN_MAX);
    endfunction

    // Append decimal run length and op letter, sometimes with a leading zero
    function automatic void add_run(int unsigned len, logic [7:0] op);
        string s;
        if ($urandom_range(0, 9) == 0)
            text_buf.insert(text_buf.size(), CH_0);
        s = $sformatf("%0d", len);
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
        text_buf.insert(text_buf.size(), op);
    endfunction

    // Stream text_buf, one character per beat, with random source gaps
    task automatic send_text(logic [30:0] rs, logic minus);
        for (int i = 0; i < text_buf.size(); i++) begin
            while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
                chan_in.valid <= 1'b0;
                @(posedge i_clk);
            end
            chan_in.valid        <= 1'b1;
            chan_in.text_char    <= text_buf[i];
            chan_in.last_char    <= (i == text_buf.size() - 1);
            chan_in.ref_start    <= rs;
            chan_in.minus_strand <= minus;
            @(posedge i_clk);
            while (!chan_in.ready)
                @(posedge i_clk);
        end
    endtask

    task automatic send_string(string unit, int reps, logic [30:0] rs, logic minus);
        text_buf.delete();
        repeat (reps) begin
            for (int i = 0; i < unit.len(); i++)
                text_buf.insert(text_buf.size(), unit[i]);
        end
        send_text(rs, minus);
    endtask

    // Stimulus
    initial begin
        int unsigned n_chars;
        int unsigned n_texts;
        int unsigned kind;
        int unsigned n_ops;
        logic [30:0] rs;

        chan_in.valid        <= 1'b0;
        chan_in.text_char    <= '0;
        chan_in.last_char    <= 1'b0;
        chan_in.ref_start    <= '0;
        chan_in.minus_strand <= 1'b0;
        i_rst_n              <= 1'b0;
        steady                = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every op, clips on both ends and both strands
        send_string("10M", 1, '0, 1'b0);
        send_string("5S10M3S", 1, REF_MAX, 1'b1);
        send_string("5S10M3S", 1, 31'd1000, 1'b0);
        send_string("3H2S4M1I2D5N1P3=2X1S4H", 1, 31'd77, 1'b1);
        send_string("3H2S4M1I2D5N1P3=2X1S4H", 1, 31'd77, 1'b0);
        send_string("7S", 1, 31'd5, 1'b0);
        // ops of length zero
        send_string("0M", 1, 31'd12, 1'b0);
        send_string("0H5M0S", 1, 31'd3, 1'b1);
        // malformed: letter without digits, trailing digits, unknown characters
        send_string("M", 1, 31'd9, 1'b0);
        send_string("5MM", 1, 31'd9, 1'b1);
        send_string("5M7", 1, 31'd9, 1'b0);
        send_string("0", 1, 31'd9, 1'b0);
        send_string("10Q", 1, 31'd9, 1'b1);
        send_string("5M*3M", 1, 31'd9, 1'b0);
        text_buf = '{8'hFF};
        send_text(REF_MAX, 1'b1);
        // run length right at and just past its limit
        send_string("268435455M", 1, 31'd1, 1'b0);
        send_string("268435456M", 1, 31'd1, 1'b1);
        // query span, reference span and end coordinate overflow
        send_string("268435455H", 17, 31'd0, 1'b0);
        send_string("268435455D", 17, 31'd0, 1'b1);
        send_string("268435455N", 8, REF_MAX, 1'b0);
        send_string("268435455N", 9, REF_MAX, 1'b0);

        // random: mostly well-formed texts, the rest broken or noise
        n_chars = 0;
        n_texts = 0;
        while (n_chars < 250) begin
            steady = (n_texts >= 3 && n_texts < 9);
            text_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                // pure noise bytes
                repeat ($urandom_range(1, 6))
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
            end else begin
                n_ops = $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                    add_run(rand_len(), $urandom_range(0, 1) ? CH_S : CH_H);
                repeat (n_ops)
                    add_run(rand_len(), op_letter($urandom_range(0, 8)));
                if ($urandom_range(0, 3) == 0)
                    add_run(rand_len(), $urandom_range(0, 1) ? CH_S : CH_H);
                if (kind < 25) begin
                    case (kind % 4)
                        0: text_buf.insert($urandom_range(0, text_buf.size()),
                                           8'($urandom_range(0, 255)));
                        1: text_buf.insert(text_buf.size(),
                                           op_letter($urandom_range(0, 8)));
                        2: text_buf.insert(text_buf.size(),
                                           8'(CH_0 + $urandom_range(0, 9)));
                        default: add_run($urandom_range(RUN_MAX + 1, 999999999),
                                         op_letter($urandom_range(0, 8)));
                    endcase
                end
            end
            case ($urandom_range(0, 9))
                0:       rs = '0;
                1:       rs = REF_MAX;
                default: rs = 31'($urandom());
            endcase
            n_chars += text_buf.size();
            n_texts++;
            send_text(rs, 1'($urandom_range(0, 1)));
        end
        chan_in.valid <= 1'b0;
        steady = 1'b0;

        // let the monitor note the final beat, drain results, then settle
        @(posedge i_clk);
        while (checker_h.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

// File: cigar_text_alignment_geometry.f
rtl/cig_pkg.sv
rtl/cig_if.sv
rtl/cig_front.sv
rtl/cig_queue.sv
rtl/cig_back.sv
rtl/cigar_text_alignment_geometry.sv
verif/cigar_text_alignment_geometry_tb.sv
